/* rtl/core/ghb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_pkg: shared types and constants of the interval hit binning core
// band table geometry, command codes, chain transaction format
// ----------------------------------------------------------------------------
package ghb_pkg;

	// table geometry
	localparam int NUM_BANDS  = 1024;
	localparam int CELL_COUNT = 16;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int ROWS       = (NUM_BANDS + CELL_COUNT - 1) / CELL_COUNT;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W      = CELL_W + ROW_W;

	// field widths
	localparam int CMD_W   = 2;
	localparam int BAND_W  = 10;
	localparam int CHROM_W = 6;
	localparam int POS_W   = 32;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 11;
	localparam int CMP_W   = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

	// command codes on the request channel
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	// operation carried along the cell chain
	typedef enum logic [1:0] {
		OP_CLR,
		OP_LOAD,
		OP_ADD,
		OP_READ
	} op_t;

	// one chain transaction; val_a is start or position, val_b is end, count or result
	typedef struct packed {
		logic              valid;
		logic              last;
		op_t               op;
		logic [IDX_W-1:0]  bidx;
		logic [BAND_W-1:0] target;
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0]  val_a;
		logic [CNT_W-1:0]  val_b;
	} tok_t;

	// one band table entry
	typedef struct packed {
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0]   first;
		logic [POS_W-1:0]   last_pos;
	} tab_t;

	localparam int TAB_W = $bits(tab_t);

endpackage
`default_nettype wire

/* rtl/core/ghb_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_if: request and response channels of the interval hit binning core
// valid/ready handshake with the payload fields of each channel
// ----------------------------------------------------------------------------
interface ghb_req_if;
	logic                          valid;
	logic                          ready;
	logic [ghb_pkg::CMD_W-1:0]     cmd;
	logic [ghb_pkg::BAND_W-1:0]    band_index;
	logic [ghb_pkg::CHROM_W-1:0]   chrom;
	logic [ghb_pkg::POS_W-1:0]     range_start;
	logic [ghb_pkg::POS_W-1:0]     range_end;
	logic [ghb_pkg::POS_W-1:0]     position;
	logic [ghb_pkg::CNT_W-1:0]     hit_count;

	modport source (
		output valid, cmd, band_index, chrom, range_start, range_end, position, hit_count,
		input  ready
	);
	modport sink (
		input  valid, cmd, band_index, chrom, range_start, range_end, position, hit_count,
		output ready
	);
endinterface

interface ghb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ghb_pkg::BAND_W-1:0] read_index;
	logic [ghb_pkg::CNT_W-1:0]  band_total;
	logic [ghb_pkg::CNT_W-1:0]  all_hits;

	modport source (
		output valid, read_index, band_total, all_hits,
		input  ready
	);
	modport sink (
		input  valid, read_index, band_total, all_hits,
		output ready
	);
endinterface
`default_nettype wire

/* rtl/core/ghb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ghb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/ghb_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_cell: one cell of the band chain
// owns one band of every row; matches, accumulates and forwards transactions
// ----------------------------------------------------------------------------
module ghb_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ghb_pkg::tok_t                tok_in,
	input  wire logic [ghb_pkg::CMP_W-1:0]    lim,
	output ghb_pkg::tok_t                     tok_out
);

	ghb_pkg::tok_t tok_s1;
	ghb_pkg::tok_t tok_s2;
	ghb_pkg::tok_t tok_nx;
	ghb_pkg::tab_t tab_rd;
	ghb_pkg::tab_t tab_wr;

	logic [ghb_pkg::TAB_W-1:0]  tab_rd_raw;
	logic [ghb_pkg::CNT_W-1:0]  acc_rd;
	logic [ghb_pkg::CNT_W-1:0]  acc_wr;
	logic [ghb_pkg::CNT_W:0]    sum;
	logic [ghb_pkg::ROW_W-1:0]  rd_row;
	logic [ghb_pkg::ROW_W-1:0]  wr_row;
	logic                       tab_we;
	logic                       acc_we;
	logic                       is_target;
	logic                       in_use;
	logic                       covers;

	assign rd_row = tok_in.bidx[ghb_pkg::IDX_W-1:ghb_pkg::CELL_W];
	assign wr_row = tok_s1.bidx[ghb_pkg::IDX_W-1:ghb_pkg::CELL_W];
	assign tab_rd = ghb_pkg::tab_t'(tab_rd_raw);

	ghb_ram #(
		.WIDTH (ghb_pkg::TAB_W),
		.DEPTH (ghb_pkg::ROWS)
	) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (wr_row),
		.wdata (tab_wr),
		.raddr (rd_row),
		.rdata (tab_rd_raw)
	);

	ghb_ram #(
		.WIDTH (ghb_pkg::CNT_W),
		.DEPTH (ghb_pkg::ROWS)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (wr_row),
		.wdata (acc_wr),
		.raddr (rd_row),
		.rdata (acc_rd)
	);

	always_comb begin
		is_target = (ghb_pkg::CMP_W'(tok_s1.bidx) == ghb_pkg::CMP_W'(tok_s1.target));
		in_use    = (ghb_pkg::CMP_W'(tok_s1.bidx) < lim);
		covers    = (tab_rd.chrom == tok_s1.chrom) &&
		            (tok_s1.val_a >= tab_rd.first) &&
		            (tok_s1.val_a <= tab_rd.last_pos);
		sum       = {1'b0, acc_rd} + {1'b0, tok_s1.val_b};

		tab_wr.chrom    = tok_s1.chrom;
		tab_wr.first    = tok_s1.val_a;
		tab_wr.last_pos = tok_s1.val_b;
		tab_we          = 1'b0;
		acc_we          = 1'b0;
		acc_wr          = sum[ghb_pkg::CNT_W] ? '1 : sum[ghb_pkg::CNT_W-1:0];
		tok_nx          = tok_s1;
		// next cell owns the next band of the same row
		tok_nx.bidx     = tok_s1.bidx + ghb_pkg::IDX_W'(1);

		unique case (tok_s1.op)
			ghb_pkg::OP_CLR: begin
				acc_we = tok_s1.valid;
				acc_wr = '0;
			end
			ghb_pkg::OP_LOAD: begin
				tab_we = tok_s1.valid && is_target;
			end
			ghb_pkg::OP_ADD: begin
				// saturating accumulate for every in-use band covering the hit
				acc_we = tok_s1.valid && in_use && covers;
			end
			ghb_pkg::OP_READ: begin
				if (is_target) begin
					tok_nx.val_b = acc_rd;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_nx;
		end
	end

	assign tok_out = tok_s2;

endmodule
`default_nettype wire

/* rtl/core/genomic_interval_hit_binning_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// genomic_interval_hit_binning_core: banded hit counter on a chain of cells
// band table spread over a row of cells, hit counts accumulated per band
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake      | carries
//  ---------+-----+----------------+-----------------------------------------
//  req      | in  | valid/ready    | cmd, band_index, chrom, range_start,
//           |     |                | range_end, position, hit_count
//  rsp      | out | valid/ready    | read_index, band_total, all_hits
//  cfg      | in  | cfg_we only    | bands_in_use (11 bits)
//
//  one request at a time; the chain has CELL_COUNT cells of two stages each
//  load or read: one transaction walks every cell; a read result then moves
//  through the result register into the output register
//  add: one transaction per row enters the chain; after reset a clearing pass
//  zeroes all counters with req.ready low; cfg writes are taken at any time
//  a waiting response holds in the output register while new requests are taken
//
module genomic_interval_hit_binning_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [ghb_pkg::CFG_W-1:0]  cfg_wdata,
	ghb_req_if.sink                         req,
	ghb_rsp_if.source                       rsp
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD,
		S_DRAIN,
		S_PUSH
	} state_t;

	localparam logic [ghb_pkg::ROW_W-1:0] LAST_ROW = ghb_pkg::ROW_W'(ghb_pkg::ROWS - 1);
	localparam logic [ghb_pkg::CMP_W-1:0] BAND_LIM = ghb_pkg::CMP_W'(ghb_pkg::NUM_BANDS);

	state_t                        state_q;
	logic [ghb_pkg::ROW_W-1:0]     row_q;
	ghb_pkg::tok_t                 inj_q;
	logic [ghb_pkg::CFG_W-1:0]     cfg_q;
	logic [ghb_pkg::CMP_W-1:0]     lim_q;
	logic [ghb_pkg::CNT_W-1:0]     hits_q;
	logic [ghb_pkg::BAND_W-1:0]    res_idx_q;
	logic [ghb_pkg::CNT_W-1:0]     res_tot_q;
	logic                          rsp_valid_q;
	logic [ghb_pkg::BAND_W-1:0]    rsp_idx_q;
	logic [ghb_pkg::CNT_W-1:0]     rsp_tot_q;
	logic [ghb_pkg::CNT_W-1:0]     rsp_all_q;

	// chain links: link 0 is the injector, the last link is the tail
	ghb_pkg::tok_t                 chain [ghb_pkg::CELL_COUNT+1];
	ghb_pkg::tok_t                 tail;

	logic [ghb_pkg::CMP_W-1:0]     lim_nx;
	logic [ghb_pkg::CNT_W:0]       hits_sum;
	logic [ghb_pkg::ROW_W-1:0]     req_row;
	logic                          row_last;
	logic                          rsp_push;

	assign chain[0] = inj_q;
	assign tail     = chain[ghb_pkg::CELL_COUNT];

	for (genvar k = 0; k < ghb_pkg::CELL_COUNT; k++) begin : g_cell
		ghb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[k]),
			.lim     (lim_q),
			.tok_out (chain[k+1])
		);
	end

	// bands in use, capped at the table size
	assign lim_nx   = (ghb_pkg::CMP_W'(cfg_q) > BAND_LIM) ? BAND_LIM : ghb_pkg::CMP_W'(cfg_q);
	assign hits_sum = {1'b0, hits_q} + {1'b0, req.hit_count};
	// row holding the addressed band; cell k of that row sees bidx = row base + k
	assign req_row  = ghb_pkg::ROW_W'(req.band_index >> ghb_pkg::CELL_W);
	assign row_last = (row_q == LAST_ROW);
	// read result moves to the output register when that register is free
	assign rsp_push = (state_q == S_PUSH) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			row_q       <= '0;
			inj_q       <= '0;
			cfg_q       <= '0;
			lim_q       <= '0;
			hits_q      <= '0;
			res_idx_q   <= '0;
			res_tot_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_idx_q   <= '0;
			rsp_tot_q   <= '0;
			rsp_all_q   <= '0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (rsp_push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					// one clearing transaction per row, all cells zero their counter
					inj_q.valid <= 1'b1;
					inj_q.op    <= ghb_pkg::OP_CLR;
					inj_q.bidx  <= {row_q, {ghb_pkg::CELL_W{1'b0}}};
					inj_q.last  <= row_last;
					if (row_last) begin
						row_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						inj_q.target <= req.band_index;
						inj_q.chrom  <= req.chrom;
						unique case (req.cmd)
							ghb_pkg::CMD_LOAD: begin
								inj_q.valid <= 1'b1;
								inj_q.last  <= 1'b1;
								inj_q.op    <= ghb_pkg::OP_LOAD;
								inj_q.bidx  <= {req_row, {ghb_pkg::CELL_W{1'b0}}};
								inj_q.val_a <= req.range_start;
								inj_q.val_b <= req.range_end;
								state_q     <= S_DRAIN;
							end
							ghb_pkg::CMD_READ: begin
								// val_b picks up the counter of the addressed band
								inj_q.valid <= 1'b1;
								inj_q.last  <= 1'b1;
								inj_q.op    <= ghb_pkg::OP_READ;
								inj_q.bidx  <= {req_row, {ghb_pkg::CELL_W{1'b0}}};
								inj_q.val_a <= '0;
								inj_q.val_b <= '0;
								state_q     <= S_DRAIN;
							end
							ghb_pkg::CMD_ADD: begin
								inj_q.valid <= 1'b1;
								inj_q.last  <= (LAST_ROW == '0);
								inj_q.op    <= ghb_pkg::OP_ADD;
								inj_q.bidx  <= '0;
								inj_q.val_a <= req.position;
								inj_q.val_b <= req.hit_count;
								lim_q       <= lim_nx;
								hits_q      <= hits_sum[ghb_pkg::CNT_W] ? '1 :
								               hits_sum[ghb_pkg::CNT_W-1:0];
								if (LAST_ROW == '0) begin
									state_q <= S_DRAIN;
								end else begin
									row_q   <= ghb_pkg::ROW_W'(1);
									state_q <= S_ADD;
								end
							end
							default: begin
								// unused code: taken and dropped
								inj_q.valid <= 1'b0;
							end
						endcase
					end else begin
						inj_q.valid <= 1'b0;
					end
				end
				S_ADD: begin
					// one add transaction per row, same hit payload
					inj_q.valid <= 1'b1;
					inj_q.bidx  <= {row_q, {ghb_pkg::CELL_W{1'b0}}};
					inj_q.last  <= row_last;
					if (row_last) begin
						row_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// wait for the last transaction to leave the tail cell
					inj_q.valid <= 1'b0;
					if (tail.valid && tail.last) begin
						if (tail.op == ghb_pkg::OP_READ) begin
							res_idx_q <= tail.target;
							res_tot_q <= tail.val_b;
							state_q   <= S_PUSH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PUSH: begin
					// move the read result into the output register once it is free
					inj_q.valid <= 1'b0;
					if (rsp_push) begin
						rsp_idx_q <= res_idx_q;
						rsp_tot_q <= res_tot_q;
						rsp_all_q <= hits_q;
						state_q   <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_index = rsp_idx_q;
	assign rsp.band_total = rsp_tot_q;
	assign rsp.all_hits   = rsp_all_q;

endmodule
`default_nettype wire

/* rtl/core/ghb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghb_checker: port-level checks of the interval hit binning core
// watches the request and response channels, bound to the top level
// ----------------------------------------------------------------------------
module ghb_port_checks (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic [ghb_pkg::CMD_W-1:0]   req_cmd,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [ghb_pkg::BAND_W-1:0]  rsp_read_index,
	input wire logic [ghb_pkg::CNT_W-1:0]   rsp_band_total,
	input wire logic [ghb_pkg::CNT_W-1:0]   rsp_all_hits
);

	// a stalled response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_index) &&
			$stable(rsp_band_total) && $stable(rsp_all_hits))
		else $error("response changed while stalled");

	// a working command occupies the chain, so no request is taken right after it
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready &&
			(req_cmd == ghb_pkg::CMD_LOAD || req_cmd == ghb_pkg::CMD_ADD ||
			 req_cmd == ghb_pkg::CMD_READ)
		|=> !req_ready)
		else $error("request taken while chain busy");

	// clearing pass keeps requests out right after reset
	a_clear_after_reset: assert property (@(posedge clk)
		!arst_n |=> !req_ready)
		else $error("request ready during clearing pass");

endmodule

bind genomic_interval_hit_binning_core ghb_port_checks u_ghb_port_checks (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_cmd        (req.cmd),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_index (rsp.read_index),
	.rsp_band_total (rsp.band_total),
	.rsp_all_hits   (rsp.all_hits)
);
`default_nettype wire

/* tb/ghb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghb_checker: band count predictor and response scoreboard
// follows every accepted request and config write, keeps its own band table,
// and compares each response against the oldest predicted band report
// ----------------------------------------------------------------------------
module ghb_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ghb_pkg::CFG_W-1:0] cfg_wdata,
	ghb_req_if                        req,
	ghb_rsp_if                        rsp,
	output int                        fail_count,
	output int                        due_count,
	output int                        loads_seen,
	output int                        adds_seen,
	output int                        reads_seen
);
	import ghb_pkg::*;

	typedef struct packed {
		logic [BAND_W-1:0] index;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  hits;
	} band_report_t;

	logic [CHROM_W-1:0] band_chrom [NUM_BANDS];
	logic [POS_W-1:0]   band_lo    [NUM_BANDS];
	logic [POS_W-1:0]   band_hi    [NUM_BANDS];
	logic [CNT_W-1:0]   band_acc   [NUM_BANDS];
	logic [CNT_W-1:0]   grand_total;
	logic [CFG_W-1:0]   active_bands;
	band_report_t       reports_due [$];

	initial begin
		fail_count = 0;
		due_count  = 0;
		loads_seen = 0;
		adds_seen  = 0;
		reads_seen = 0;
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a, b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	function automatic void apply_request(
		input logic [CMD_W-1:0]   cmd,
		input logic [BAND_W-1:0]  idx,
		input logic [CHROM_W-1:0] chrom,
		input logic [POS_W-1:0]   lo,
		input logic [POS_W-1:0]   hi,
		input logic [POS_W-1:0]   pos,
		input logic [CNT_W-1:0]   cnt
	);
		int span;
		band_report_t due;
		span = (active_bands > NUM_BANDS) ? NUM_BANDS : int'(active_bands);
		case (cmd)
		CMD_LOAD: begin
			loads_seen++;
			if (idx < NUM_BANDS) begin
				band_chrom[idx] = chrom;
				band_lo[idx]    = lo;
				band_hi[idx]    = hi;
			end
		end
		CMD_ADD: begin
			adds_seen++;
			for (int b = 0; b < span; b++) begin
				if (band_chrom[b] == chrom && pos >= band_lo[b] && pos <= band_hi[b])
					band_acc[b] = sat_sum(band_acc[b], cnt);
			end
			grand_total = sat_sum(grand_total, cnt);
		end
		CMD_READ: begin
			due.index = idx;
			due.total = (idx < NUM_BANDS) ? band_acc[idx] : '0;
			due.hits  = grand_total;
			reports_due = {reports_due, due};
		end
		default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		band_report_t got;
		band_report_t want;
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANDS; b++)
				band_acc[b] = '0;
			grand_total  = '0;
			active_bands = '0;
			reports_due.delete();
		end else begin
			if (cfg_we)
				active_bands = cfg_wdata;
			if (req.valid && req.ready)
				apply_request(req.cmd, req.band_index, req.chrom, req.range_start,
					req.range_end, req.position, req.hit_count);
			if (rsp.valid && rsp.ready) begin
				got.index = rsp.read_index;
				got.total = rsp.band_total;
				got.hits  = rsp.all_hits;
				if (reports_due.size() == 0) begin
					report($sformatf("response for band %0d with no read outstanding",
						got.index));
				end else begin
					want = reports_due.pop_front();
					reads_seen++;
					if (got.index !== want.index)
						report($sformatf("read_index %0d, predicted %0d",
							got.index, want.index));
					if (got.total !== want.total)
						report($sformatf("band %0d band_total %0h, predicted %0h",
							want.index, got.total, want.total));
					if (got.hits !== want.hits)
						report($sformatf("band %0d all_hits %0h, predicted %0h",
							want.index, got.hits, want.hits));
				end
			end
		end
		due_count <= reports_due.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the interval hit binning core
// directed band edge cases, a load of the low part of the table, then random
// load/add/read traffic under three idling modes and several bands-in-use
// settings, finishing with counter saturation; the checker scores every response
// ----------------------------------------------------------------------------
module testbench;
	import ghb_pkg::*;

	// unused command code, the block must drop it without a trace
	localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;
	// an add walks every row through the chain, give it a bit more than that
	localparam int SETTLE_CYCLES    = 128;
	localparam int RANDOM_PER_PHASE = 130;
	// bands loaded up front; every bands-in-use setting stays within them
	localparam int FILL_BANDS       = 256;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	int fail_count;
	int due_count;
	int loads_seen;
	int adds_seen;
	int reads_seen;

	// per-cycle idle chances of both channel ends, in percent
	int req_idle_pct;
	int rsp_idle_pct;

	// base of the position window that most bands and hits fall into
	logic [POS_W-1:0] win_lo;
	logic [CFG_W-1:0] mid_setting;

	ghb_req_if req_ch ();
	ghb_rsp_if rsp_ch ();

	genomic_interval_hit_binning_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	ghb_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.due_count  (due_count),
		.loads_seen (loads_seen),
		.adds_seen  (adds_seen),
		.reads_seen (reads_seen)
	);

	// 20 ns clock, low half first
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// response side back-pressure, one decision per cycle
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
	end

	// hard stop in case the block hangs
	initial begin
		#30_000_000;
		$display("timeout: block stopped taking or returning transactions");
		$display("testbench NOT OK");
		$finish;
	end

	// one request transaction: optional idle cycles, then hold until accepted
	task automatic send_item(
		input logic [CMD_W-1:0]   cmd,
		input logic [BAND_W-1:0]  idx,
		input logic [CHROM_W-1:0] chrom,
		input logic [POS_W-1:0]   lo,
		input logic [POS_W-1:0]   hi,
		input logic [POS_W-1:0]   pos,
		input logic [CNT_W-1:0]   cnt
	);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= cmd;
		req_ch.band_index  <= idx;
		req_ch.chrom       <= chrom;
		req_ch.range_start <= lo;
		req_ch.range_end   <= hi;
		req_ch.position    <= pos;
		req_ch.hit_count   <= cnt;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// fields a command does not use get random junk
	task automatic load_band(input logic [BAND_W-1:0] idx, input logic [CHROM_W-1:0] chrom,
		input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
		send_item(CMD_LOAD, idx, chrom, lo, hi, $urandom, $urandom);
	endtask

	task automatic add_hits(input logic [CHROM_W-1:0] chrom, input logic [POS_W-1:0] pos,
		input logic [CNT_W-1:0] cnt);
		send_item(CMD_ADD, BAND_W'($urandom), chrom, $urandom, $urandom, pos, cnt);
	endtask

	task automatic read_band(input logic [BAND_W-1:0] idx);
		send_item(CMD_READ, idx, CHROM_W'($urandom), $urandom, $urandom, $urandom,
			$urandom);
	endtask

	// drop valid, wait until every read has been answered, then let any
	// add still walking the chain drain out
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// bands-in-use only changes with the block idle
	task automatic write_setting(input logic [CFG_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly bands inside the hit window on a few chromosomes, some empty
	// (first above last), a few spread over the whole position range
	task automatic pick_band(output logic [CHROM_W-1:0] chrom, output logic [POS_W-1:0] lo,
		output logic [POS_W-1:0] hi);
		chrom = ($urandom_range(7) == 0) ? CHROM_W'($urandom) : CHROM_W'($urandom_range(3));
		if ($urandom_range(15) == 0) begin
			lo = $urandom;
			hi = $urandom;
		end else begin
			lo = win_lo + $urandom_range(6000);
			hi = lo + $urandom_range(2500);
			if ($urandom_range(9) == 0)
				hi = lo - 1 - $urandom_range(50);
		end
	endtask

	// random traffic; ignored transactions do not count toward n
	task automatic random_phase(input int n, input bit drain_midway);
		int done;
		int pick;
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_item(CMD_IDLE, BAND_W'($urandom), CHROM_W'($urandom), $urandom,
					$urandom, $urandom, $urandom);
				continue;
			end
			if (pick < 45) begin
				// hit inside the band window, the case that moves counters
				add_hits(CHROM_W'($urandom_range(3)), win_lo + $urandom_range(9000),
					($urandom_range(9) == 0) ? '0 : CNT_W'($urandom_range(4000)));
			end else if (pick < 53) begin
				// stray hit anywhere
				add_hits(CHROM_W'($urandom), $urandom, $urandom_range(4000));
			end else if (pick < 78) begin
				read_band(BAND_W'($urandom));
			end else begin
				pick_band(chrom, lo, hi);
				load_band(BAND_W'($urandom), chrom, lo, hi);
			end
			done++;
			// sender holds off until the block has answered everything
			if (drain_midway && done == n / 2)
				settle();
		end
	endtask

	initial begin
		logic [CHROM_W-1:0] chrom;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;

		// every input known from time zero
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_LOAD;
		req_ch.band_index  = '0;
		req_ch.chrom       = '0;
		req_ch.range_start = '0;
		req_ch.range_end   = '0;
		req_ch.position    = '0;
		req_ch.hit_count   = '0;
		rsp_ch.ready       = 1'b0;
		req_idle_pct       = 35;
		rsp_idle_pct       = 49;
		win_lo             = $urandom_range(32'hFFFF_0000, 32'h0001_0000);
		mid_setting        = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed: nothing in use yet ---
		write_setting('0);
		read_band(BAND_W'(NUM_BANDS - 1));  // untouched counter reads zero
		add_hits(6'd3, 32'd12345, 32'd5);   // only the running total moves
		send_item(CMD_IDLE, '1, '1, '1, '1, '1, '1);

		// hand-made bands: overlaps, edges, an empty range, top of range
		load_band(10'd0, 6'd0, 32'd0, 32'd0);
		load_band(10'd1, 6'd63, 32'd0, '1);
		load_band(10'd2, 6'd63, 32'd100, 32'd200);
		load_band(10'd3, 6'd63, 32'd150, 32'd250);
		load_band(10'd4, 6'd5, 32'd300, 32'd299);
		load_band(10'd5, 6'd5, '1, '1);
		load_band(10'd6, 6'd1, 32'd10, 32'd20);
		load_band(10'd7, 6'd1, 32'd10, 32'd20);
		write_setting(11'd8);

		add_hits(6'd63, 32'd150, 32'd7);  // three overlapping bands at once
		add_hits(6'd63, 32'd250, 32'd2);  // inclusive end of band 3, past band 2
		add_hits(6'd0, 32'd0, 32'd4);     // zero-width band at position zero
		add_hits(6'd5, 32'd299, 32'd9);   // empty band must never match
		add_hits(6'd5, 32'd300, 32'd9);
		add_hits(6'd5, '1, 32'd3);        // top position
		add_hits(6'd1, 32'd10, 32'd1);    // identical bands 6 and 7, first edge
		add_hits(6'd1, 32'd21, 32'd1);    // one past the end

		// reloading a band leaves its count alone
		load_band(10'd2, 6'd62, 32'd0, 32'd10);
		for (int b = 0; b < 8; b++)
			read_band(BAND_W'(b));

		// --- load the low part of the table so every setting below is legal ---
		for (int b = 0; b < FILL_BANDS; b++) begin
			pick_band(chrom, lo, hi);
			load_band(BAND_W'(b), chrom, lo, hi);
		end

		// --- random traffic, one idling mode per phase ---
		write_setting(CFG_W'(FILL_BANDS));
		random_phase(RANDOM_PER_PHASE, 1'b0);

		req_idle_pct = 49;
		rsp_idle_pct = 35;
		mid_setting  = CFG_W'($urandom_range(FILL_BANDS, 1));
		write_setting(mid_setting);
		random_phase(RANDOM_PER_PHASE, 1'b1);

		req_idle_pct = 0;
		rsp_idle_pct = 0;
		write_setting(CFG_W'(FILL_BANDS - 1));
		random_phase(RANDOM_PER_PHASE, 1'b0);

		// --- saturation last, the running total stays pinned afterwards ---
		load_band(10'd0, 6'd63, 32'd0, '1);
		write_setting(11'd1);
		add_hits(6'd63, '1, '1);
		add_hits(6'd63, 32'd0, 32'h8000_0000);
		read_band(10'd0);
		read_band(10'd1);  // out of use now, count frozen

		settle();

		$display("covered %0d band loads, %0d hit transactions, %0d checked reads",
			loads_seen, adds_seen, reads_seen);
		$display("bands-in-use 0, 8, %0d, %0d, %0d and 1, with three idling mixes",
			FILL_BANDS, mid_setting, FILL_BANDS - 1);
		if (fail_count == 0 && due_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ghb_pkg.sv
rtl/core/ghb_if.sv
rtl/core/ghb_ram.sv
rtl/core/ghb_cell.sv
rtl/core/genomic_interval_hit_binning_core.sv
rtl/core/ghb_checker.sv
tb/ghb_checker.sv
tb/testbench.sv
